/* sv/bdpc_pkg.sv */
// Package: shared types and constants for the button debounce press classifier.
package bdpc_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE  = 1'b0;
    localparam logic REG_LONG_HOLD = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [CFG_W-1:0] LONG_HOLD_RESET = 16'd800;

    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_hold_ms;
    } bdpc_cfg_t;

    typedef struct packed {
        logic stable_level;
        logic short_tap;
        logic long_hold;
    } bdpc_result_t;

endpackage

/* sv/bdpc_if.sv */
// Interfaces: sample and result channels with valid/ready handshake.
interface bdpc_sample_if;
    logic                       valid;
    logic                       ready;
    logic                       raw_level;
    logic [bdpc_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output raw_level, output now_ms, input ready);
    modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdpc_result_if;
    logic valid;
    logic ready;
    logic stable_level;
    logic short_tap;
    logic long_hold;

    modport source (output valid, output stable_level, output short_tap,
                    output long_hold, input ready);
    modport sink   (input valid, input stable_level, input short_tap,
                    input long_hold, output ready);
endinterface

/* sv/bdpc_cfg.sv */
// Configuration registers behind the APB-style port.
module bdpc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bdpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bdpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output bdpc_pkg::bdpc_cfg_t               cfg
);
    import bdpc_pkg::*;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_hold_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            long_hold_reg <= LONG_HOLD_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_DEBOUNCE)
            begin
                debounce_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                long_hold_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_DEBOUNCE)
        begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, debounce_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, long_hold_reg};
        end
    end

    assign cfg.debounce_ms  = debounce_reg;
    assign cfg.long_hold_ms = long_hold_reg;

endmodule

/* sv/bdpc_eval.sv */
// Debounce and press classification state with its single-pass update logic.
module bdpc_eval (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdpc_pkg::bdpc_cfg_t           cfg,
    input  logic                          fire,
    input  logic                          raw_level,
    input  logic [bdpc_pkg::TIME_W-1:0]   now_ms,
    output bdpc_pkg::bdpc_result_t        result
);
    import bdpc_pkg::*;

    logic              sampled_reg;
    logic              sampled_next;
    logic              debounced_reg;
    logic              debounced_next;
    logic [TIME_W-1:0] last_change_reg;
    logic [TIME_W-1:0] last_change_next;
    logic [TIME_W-1:0] press_start_reg;
    logic [TIME_W-1:0] press_start_next;
    logic              long_rep_reg;
    logic              long_rep_next;

    logic              raw_changed;
    logic [TIME_W-1:0] since_change;
    logic              settled;
    logic              flip;
    logic [TIME_W-1:0] held_old;
    logic              held_long;
    logic              new_press;
    logic              short_hit;
    logic              long_hit;

    assign raw_changed  = (raw_level != sampled_reg);
    assign since_change = now_ms - last_change_reg;
    assign settled      = raw_changed ? (cfg.debounce_ms == '0)
                                      : (since_change >= {{(TIME_W-CFG_W){1'b0}},
                                                          cfg.debounce_ms});
    assign flip         = settled && (debounced_reg != raw_level);
    assign held_old     = now_ms - press_start_reg;
    assign held_long    = held_old >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_hold_ms};
    assign new_press    = flip && (raw_level == LEVEL_PRESSED);

    always_comb
    begin
        sampled_next     = raw_level;
        last_change_next = raw_changed ? now_ms : last_change_reg;
        debounced_next   = flip ? raw_level : debounced_reg;
        press_start_next = new_press ? now_ms : press_start_reg;
        short_hit        = flip && (raw_level == LEVEL_RELEASED) && !held_long
                           && !long_rep_reg;
        long_hit         = 1'b0;
        long_rep_next    = new_press ? 1'b0 : long_rep_reg;
        if (debounced_next == LEVEL_PRESSED && !long_rep_next)
        begin
            // a fresh press has held for zero time
            long_hit = new_press ? (cfg.long_hold_ms == '0) : held_long;
            if (long_hit)
            begin
                long_rep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_reg     <= LEVEL_RELEASED;
            debounced_reg   <= LEVEL_RELEASED;
            last_change_reg <= '0;
            press_start_reg <= '0;
            long_rep_reg    <= 1'b0;
        end
        else if (fire)
        begin
            sampled_reg     <= sampled_next;
            debounced_reg   <= debounced_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
            long_rep_reg    <= long_rep_next;
        end
    end

    assign result.stable_level = debounced_next;
    assign result.short_tap    = short_hit;
    assign result.long_hold    = long_hit;

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(short_hit && long_hit))
        else $error("short and long press on one word");
    a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && short_hit) |-> (debounced_next == LEVEL_RELEASED))
        else $error("short press while still pressed");
    a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && long_hit) |-> (debounced_next == LEVEL_PRESSED))
        else $error("long press while released");
    a_long_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && long_hit) |=> long_rep_reg)
        else $error("long press not marked as reported");
`endif

endmodule

/* sv/button_debounce_press_classifier_core.sv */
// Top level: input register, classifier logic and result register with APB configuration.
// Accepts one sample word per clock unless a pending result word is not taken, and returns one
// result word per sample, in order; a sample passes the sample register and then the result
// register around the single-pass classifier, which updates when the result register is free
// or its word is being taken. The result register lets a new sample
// be taken while a finished result waits. Registers: debounce_ms at byte 0, the long-hold
// time in ms at byte 4; write them only while the block is idle.
module button_debounce_press_classifier_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bdpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bdpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    bdpc_sample_if.sink                       sample,
    bdpc_result_if.source                     result
);
    import bdpc_pkg::*;

    bdpc_cfg_t         cfg;
    bdpc_result_t      eval_res;

    logic              in_valid_reg;
    logic              in_raw_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    bdpc_result_t      out_data_reg;
    logic              advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    bdpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdpc_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (advance),
        .raw_level (in_raw_reg),
        .now_ms    (in_now_reg),
        .result    (eval_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_raw_reg <= sample.raw_level;
            in_now_reg <= sample.now_ms;
        end
        if (advance)
        begin
            out_data_reg <= eval_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.stable_level = out_data_reg.stable_level;
    assign result.short_tap    = out_data_reg.short_tap;
    assign result.long_hold    = out_data_reg.long_hold;

`ifndef SYNTHESIS
    a_out_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result word without a processed sample");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("pending result word overwritten");
    a_hold_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_now_reg)))
        else $error("stalled sample word lost");
`endif

endmodule
